FILE: hdl/awqps_pkg.sv
`default_nettype none
package awqps_pkg;

	localparam int unsigned MAX_QUADS_DEF  = 16;
	localparam int unsigned COORD_BITS_DEF = 16;
	localparam int unsigned FRAC_BITS_DEF  = 16;

	localparam logic OP_LOAD   = 1'b0;
	localparam logic OP_SAMPLE = 1'b1;

	localparam logic [1:0] STATUS_LOADED = 2'd0;
	localparam logic [1:0] STATUS_POINT  = 2'd1;
	localparam logic [1:0] STATUS_EMPTY  = 2'd2;

	// corner difference, cross product, doubled triangle area, doubled quad area
	localparam int unsigned DIFF_W  = 17;
	localparam int unsigned CROSS_W = 2 * DIFF_W;
	localparam int unsigned TRI_W   = 34;
	localparam int unsigned QUAD_W  = TRI_W + 1;
	localparam int unsigned SUM_W   = DIFF_W + 3;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_READ,
		ST_WAIT,
		ST_MUL1,
		ST_MUL2,
		ST_MUL3,
		ST_ACC,
		ST_SCALE1,
		ST_SCALE2,
		ST_SCALE3,
		ST_POINT_X,
		ST_POINT_Y,
		ST_FINISH,
		ST_DONE
	} state_t;

endpackage
`default_nettype wire

FILE: hdl/area_weighted_quad_point_sampler.sv
// Area-weighted point sampler. Load words write one quad corner into a
// corner RAM (MAX_QUADS*4 words, one read per cycle, registered read) and
// answer through the done state. A sample word walks the first quad_count
// quads (at most MAX_QUADS) twice, once to total the doubled areas and once
// to find the first running sum reaching the scaled target; each quad takes
// four corner reads, a read-latency wait, three cross-product steps and one
// accumulate. The two fraction scalings are split in two partial products
// each. An empty table answers status 2 at once. One word is in flight at
// a time.
`default_nettype none
module area_weighted_quad_point_sampler
	import awqps_pkg::*;
#(
	parameter int unsigned MAX_QUADS  = MAX_QUADS_DEF,
	parameter int unsigned COORD_BITS = COORD_BITS_DEF,
	parameter int unsigned FRAC_BITS  = FRAC_BITS_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [4:0]  cfg_data,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic        op,
	input  wire logic [3:0]  quad_slot,
	input  wire logic [1:0]  vertex_index,
	input  wire logic signed [15:0] vertex_x,
	input  wire logic signed [15:0] vertex_y,
	input  wire logic [15:0] rand_quad,
	input  wire logic [15:0] rand_triangle,
	input  wire logic [15:0] rand_u,
	input  wire logic [15:0] rand_v,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [1:0]       status,
	output logic signed [15:0] point_x,
	output logic signed [15:0] point_y,
	output logic [3:0]       chosen_slot,
	output logic             second_triangle
);

	localparam int unsigned F       = FRAC_BITS;
	localparam int unsigned DEPTH   = MAX_QUADS * 4;
	localparam int unsigned AW      = $clog2(DEPTH);
	localparam int unsigned CW      = $clog2(MAX_QUADS + 1);
	localparam int unsigned TW      = QUAD_W + $clog2(MAX_QUADS);
	localparam int unsigned HW      = (TW + 1) / 2;
	localparam int unsigned HIW     = TW - HW;
	localparam int unsigned PW      = DIFF_W + F + 2;
	localparam logic signed [31:0] SAT_HI = 32'sd2 ** (COORD_BITS - 1) - 32'sd1;
	localparam logic signed [31:0] SAT_LO = -SAT_HI - 32'sd1;

	state_t state_q, state_d;

	logic [4:0]          count_q;
	logic [CW-1:0]       n_q, i_q;
	logic [1:0]          k_q;
	logic                pass_q;
	logic [F-1:0]        rq_q, rt_q, ru_q, rv_q;

	logic                rd_v_s1;
	logic [1:0]          rd_k_s1;
	logic [AW-1:0]       raddr;
	logic [31:0]         rdata;
	logic                we;

	logic signed [15:0]  cx_q [4];
	logic signed [15:0]  cy_q [4];
	logic signed [CROSS_W-1:0] m1_s, m2_s;
	logic signed [CROSS_W:0]   cdiff;
	logic [TRI_W-1:0]    a1_q, a2_q, cabs;
	logic [QUAD_W-1:0]   qa;
	logic [TW-1:0]       total_q, cum_q, cum_new, target_q;
	logic [TW-1:0]       sc_a_q, sc_res;
	logic [F-1:0]        sc_f_q;
	logic [HW+F-1:0]     lo_s;
	logic [HIW+F-1:0]    hi_s;
	logic [TW+F-1:0]     sc_full;
	logic                last_quad;
	logic [CW-1:0]       slot_q;
	logic                sec_q;

	logic [F:0]          r1, r2;
	logic [F+1:0]        rsum;
	logic signed [DIFF_W-1:0] db_x, dc_x, db_y, dc_y;
	logic signed [PW-1:0] p1_s, p2_s;
	logic signed [SUM_W-1:0] psum;
	logic signed [31:0]  pwide, psat;
	logic signed [15:0]  ax_sel, ay_sel;
	logic signed [15:0]  px_q;

	logic [1:0]          res_status_q;
	logic signed [15:0]  res_x_q, res_y_q;
	logic [3:0]          res_slot_q;
	logic                res_sec_q;

	logic                in_acc, out_free;
	logic [8:0]          n_clip;

	assign cfg_ready = 1'b1;
	assign in_stall  = (state_q != ST_IDLE);
	assign in_acc    = in_valid && !in_stall;
	assign out_free  = !out_valid || !out_stall;

	assign we    = in_acc && (op == OP_LOAD) && ({5'd0, quad_slot} < 9'(MAX_QUADS));
	assign raddr = AW'({i_q, k_q});

	awqps_ram #(
		.WIDTH (32),
		.DEPTH (DEPTH)
	) u_corners (
		.clk   (clk),
		.we    (we),
		.waddr (AW'({quad_slot, vertex_index})),
		.wdata ({vertex_y, vertex_x}),
		.raddr (raddr),
		.rdata (rdata)
	);

	assign n_clip = ({4'd0, count_q} > 9'(MAX_QUADS)) ? 9'(MAX_QUADS) : {4'd0, count_q};

	// cross product magnitude of the registered pair
	assign cdiff = (CROSS_W+1)'(m1_s) - (CROSS_W+1)'(m2_s);
	assign cabs  = cdiff[CROSS_W] ? TRI_W'(-cdiff) : TRI_W'(cdiff);
	assign qa    = QUAD_W'(a1_q) + QUAD_W'(a2_q);
	assign cum_new   = cum_q + TW'(qa);
	assign last_quad = (CW'(i_q + CW'(1)) == n_q);

	assign sc_full = {hi_s, HW'(0)} + (TW+F)'(lo_s);
	assign sc_res  = sc_full[TW+F-1:F];

	// reflect the fractions back into the triangle
	assign rsum = (F+2)'(ru_q) + (F+2)'(rv_q);
	always_comb begin
		if (rsum > (F+2)'(2 ** F)) begin
			r1 = (F+1)'(2 ** F) - (F+1)'(ru_q);
			r2 = (F+1)'(2 ** F) - (F+1)'(rv_q);
		end else begin
			r1 = (F+1)'(ru_q);
			r2 = (F+1)'(rv_q);
		end
	end

	assign ax_sel = cx_q[0];
	assign ay_sel = cy_q[0];
	assign db_x = sec_q ? DIFF_W'(cx_q[2]) - DIFF_W'(cx_q[0]) : DIFF_W'(cx_q[1]) - DIFF_W'(cx_q[0]);
	assign dc_x = sec_q ? DIFF_W'(cx_q[3]) - DIFF_W'(cx_q[0]) : DIFF_W'(cx_q[2]) - DIFF_W'(cx_q[0]);
	assign db_y = sec_q ? DIFF_W'(cy_q[2]) - DIFF_W'(cy_q[0]) : DIFF_W'(cy_q[1]) - DIFF_W'(cy_q[0]);
	assign dc_y = sec_q ? DIFF_W'(cy_q[3]) - DIFF_W'(cy_q[0]) : DIFF_W'(cy_q[2]) - DIFF_W'(cy_q[0]);

	// floor via arithmetic shift; the base corner is x in ST_POINT_Y, y in ST_FINISH
	always_comb begin
		psum = SUM_W'(state_q == ST_POINT_Y ? ax_sel : ay_sel)
			+ SUM_W'(p1_s >>> F) + SUM_W'(p2_s >>> F);
		pwide = 32'(psum);
		if (pwide > SAT_HI) begin
			psat = SAT_HI;
		end else if (pwide < SAT_LO) begin
			psat = SAT_LO;
		end else begin
			psat = pwide;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_acc) begin
					if (op == OP_LOAD || n_clip == 9'd0) begin
						state_d = ST_DONE;
					end else begin
						state_d = ST_READ;
					end
				end
			end
			ST_READ:    if (k_q == 2'd3) state_d = ST_WAIT;
			ST_WAIT:    state_d = ST_MUL1;
			ST_MUL1:    state_d = ST_MUL2;
			ST_MUL2:    state_d = ST_MUL3;
			ST_MUL3:    state_d = ST_ACC;
			ST_ACC: begin
				if (!pass_q) begin
					state_d = last_quad ? ST_SCALE1 : ST_READ;
				end else begin
					state_d = (target_q <= cum_new || last_quad) ? ST_SCALE1 : ST_READ;
				end
			end
			ST_SCALE1:  state_d = ST_SCALE2;
			ST_SCALE2:  state_d = ST_SCALE3;
			ST_SCALE3:  state_d = pass_q ? ST_POINT_X : ST_READ;
			ST_POINT_X: state_d = ST_POINT_Y;
			ST_POINT_Y: state_d = ST_FINISH;
			ST_FINISH:  state_d = ST_DONE;
			ST_DONE:    if (out_free) state_d = ST_IDLE;
			default:    state_d = ST_IDLE;
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q   <= '0;
			n_q       <= '0;
			i_q       <= '0;
			k_q       <= '0;
			pass_q    <= 1'b0;
			rd_v_s1   <= 1'b0;
			rd_k_s1   <= '0;
			out_valid <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				count_q <= cfg_data;
			end
			rd_v_s1 <= (state_q == ST_READ);
			rd_k_s1 <= k_q;
			if (state_q == ST_READ) begin
				k_q <= k_q + 2'd1;
			end
			if (in_acc) begin
				n_q    <= CW'(n_clip);
				i_q    <= '0;
				k_q    <= '0;
				pass_q <= 1'b0;
			end
			if (state_q == ST_ACC && state_d == ST_READ) begin
				i_q <= CW'(i_q + CW'(1));
			end
			if (state_q == ST_SCALE3 && !pass_q) begin
				pass_q <= 1'b1;
				i_q    <= '0;
			end
			if (state_q == ST_DONE && out_free) begin
				out_valid <= 1'b1;
			end else if (!out_stall) begin
				out_valid <= 1'b0;
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (rd_v_s1) begin
			cx_q[rd_k_s1] <= rdata[15:0];
			cy_q[rd_k_s1] <= rdata[31:16];
		end
		case (state_q)
			ST_IDLE: begin
				rq_q         <= F'(rand_quad);
				rt_q         <= F'(rand_triangle);
				ru_q         <= F'(rand_u);
				rv_q         <= F'(rand_v);
				total_q      <= '0;
				cum_q        <= '0;
				res_status_q <= (op == OP_LOAD) ? STATUS_LOADED : STATUS_EMPTY;
				res_x_q      <= '0;
				res_y_q      <= '0;
				res_slot_q   <= '0;
				res_sec_q    <= 1'b0;
			end
			ST_MUL1: begin
				m1_s <= (DIFF_W'(cx_q[1]) - DIFF_W'(cx_q[0])) * (DIFF_W'(cy_q[2]) - DIFF_W'(cy_q[0]));
				m2_s <= (DIFF_W'(cy_q[1]) - DIFF_W'(cy_q[0])) * (DIFF_W'(cx_q[2]) - DIFF_W'(cx_q[0]));
			end
			ST_MUL2: begin
				a1_q <= cabs;
				m1_s <= (DIFF_W'(cx_q[2]) - DIFF_W'(cx_q[0])) * (DIFF_W'(cy_q[3]) - DIFF_W'(cy_q[0]));
				m2_s <= (DIFF_W'(cy_q[2]) - DIFF_W'(cy_q[0])) * (DIFF_W'(cx_q[3]) - DIFF_W'(cx_q[0]));
			end
			ST_MUL3: begin
				a2_q <= cabs;
			end
			ST_ACC: begin
				if (!pass_q) begin
					total_q <= total_q + TW'(qa);
					sc_a_q  <= total_q + TW'(qa);
					sc_f_q  <= rq_q;
				end else begin
					cum_q  <= cum_new;
					sc_a_q <= TW'(qa);
					sc_f_q <= rt_q;
					slot_q <= i_q;
				end
			end
			ST_SCALE1: begin
				lo_s <= sc_a_q[HW-1:0] * sc_f_q;
			end
			ST_SCALE2: begin
				hi_s <= sc_a_q[TW-1:HW] * sc_f_q;
			end
			ST_SCALE3: begin
				if (!pass_q) begin
					target_q <= sc_res;
					cum_q    <= '0;
				end else begin
					sec_q <= (sc_res > TW'(a1_q));
				end
			end
			ST_POINT_X: begin
				p1_s <= db_x * $signed({1'b0, r1});
				p2_s <= dc_x * $signed({1'b0, r2});
			end
			ST_POINT_Y: begin
				px_q <= psat[15:0];
				p1_s <= db_y * $signed({1'b0, r1});
				p2_s <= dc_y * $signed({1'b0, r2});
			end
			ST_FINISH: begin
				res_status_q <= STATUS_POINT;
				res_x_q      <= px_q;
				res_y_q      <= psat[15:0];
				res_slot_q   <= 4'(slot_q);
				res_sec_q    <= sec_q;
			end
			default: begin
			end
		endcase
		if (state_q == ST_DONE && out_free) begin
			status          <= res_status_q;
			point_x         <= res_x_q;
			point_y         <= res_y_q;
			chosen_slot     <= res_slot_q;
			second_triangle <= res_sec_q;
		end
	end

`ifndef SYNTHESIS
	a_read_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_READ) |-> (i_q < n_q))
		else $error("quad index ran past the sampled count");

	a_slot_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FINISH) |-> (slot_q < n_q))
		else $error("chosen slot outside the sampled count");

	a_done_emits: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DONE && out_free) |=> (out_valid && state_q == ST_IDLE))
		else $error("finished word not presented");

	a_no_busy_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE && state_q != ST_DONE) |=> !out_valid || $past(out_valid))
		else $error("result appeared while a sample was still in work");
`endif

endmodule
`default_nettype wire

FILE: hdl/awqps_ram.sv
`default_nettype none
module awqps_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule
`default_nettype wire

FILE: tb/area_weighted_quad_point_sampler_test.sv
module area_weighted_quad_point_sampler_test
	import awqps_pkg::*;
;
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct {
		logic        op;
		logic [3:0]  slot;
		logic [1:0]  corner;
		logic signed [15:0] x;
		logic signed [15:0] y;
		logic [15:0] rq;
		logic [15:0] rt;
		logic [15:0] ru;
		logic [15:0] rv;
	} word_t;

	typedef struct {
		logic [1:0]  status;
		logic signed [15:0] px;
		logic signed [15:0] py;
		logic [3:0]  slot;
		logic        sec;
	} point_t;

	class point_scoreboard;
		logic signed [15:0] cx[64];
		logic signed [15:0] cy[64];
		logic [4:0] active_quads;
		point_t pending[$];
		int errors;

		function new();
			active_quads = 0;
			errors = 0;
		endfunction

		function longint tri_area(int s, int a, int b, int c);
			longint ax, ay, cr;
			ax = cx[s*4+a];
			ay = cy[s*4+a];
			cr = (cx[s*4+b] - ax) * (cy[s*4+c] - ay) - (cy[s*4+b] - ay) * (cx[s*4+c] - ax);
			return cr < 0 ? -cr : cr;
		endfunction

		function logic signed [15:0] clamp(longint v);
			if (v > 32767)
				return 16'sh7fff;
			if (v < -32768)
				return 16'sh8000;
			return v[15:0];
		endfunction

		function void note_word(word_t w);
			point_t e;
			int n, s, ib, ic, i;
			longint total, cum, target, a1, a2, r1, r2, ax, ay, vx, vy;
			e = '{STATUS_LOADED, 0, 0, 0, 0};
			if (w.op == OP_LOAD) begin
				cx[w.slot*4+w.corner] = w.x;
				cy[w.slot*4+w.corner] = w.y;
			end else begin
				n = active_quads > 16 ? 16 : active_quads;
				if (n == 0) begin
					e.status = STATUS_EMPTY;
				end else begin
					total = 0;
					for (i = 0; i < n; i++)
						total += tri_area(i, 0, 1, 2) + tri_area(i, 0, 2, 3);
					target = (total * longint'(w.rq)) >> 16;
					s = n - 1;
					cum = 0;
					for (i = 0; i < n; i++) begin
						cum += tri_area(i, 0, 1, 2) + tri_area(i, 0, 2, 3);
						if (target <= cum) begin
							s = i;
							break;
						end
					end
					a1 = tri_area(s, 0, 1, 2);
					a2 = tri_area(s, 0, 2, 3);
					e.sec = (((a1 + a2) * longint'(w.rt)) >> 16) > a1;
					ib = e.sec ? 2 : 1;
					ic = e.sec ? 3 : 2;
					r1 = w.ru;
					r2 = w.rv;
					// reflect back into the triangle
					if (r1 + r2 > 65536) begin
						r1 = 65536 - r1;
						r2 = 65536 - r2;
					end
					ax = cx[s*4];
					ay = cy[s*4];
					vx = ax + (((cx[s*4+ib] - ax) * r1) >>> 16)
						+ (((cx[s*4+ic] - ax) * r2) >>> 16);
					vy = ay + (((cy[s*4+ib] - ay) * r1) >>> 16)
						+ (((cy[s*4+ic] - ay) * r2) >>> 16);
					e.status = STATUS_POINT;
					e.px = clamp(vx);
					e.py = clamp(vy);
					e.slot = s[3:0];
				end
			end
			pending.insert(pending.size(), e);
		endfunction

		function void check_point(point_t a);
			point_t e;
			if (pending.size() == 0) begin
				$display("%0t: unexpected result word status %0d", $time, a.status);
				errors++;
				return;
			end
			e = pending.pop_front();
			if (a.status !== e.status) begin
				$display("%0t: status expected %0d actual %0d", $time, e.status, a.status);
				errors++;
			end
			if (a.px !== e.px) begin
				$display("%0t: point_x expected %0d actual %0d", $time, e.px, a.px);
				errors++;
			end
			if (a.py !== e.py) begin
				$display("%0t: point_y expected %0d actual %0d", $time, e.py, a.py);
				errors++;
			end
			if (a.slot !== e.slot) begin
				$display("%0t: chosen_slot expected %0d actual %0d", $time, e.slot, a.slot);
				errors++;
			end
			if (a.sec !== e.sec) begin
				$display("%0t: second_triangle expected %0d actual %0d", $time, e.sec, a.sec);
				errors++;
			end
		endfunction
	endclass

	logic clk = 0;
	logic arst_n = 0;
	logic cfg_valid = 0;
	logic cfg_ready;
	logic [4:0] cfg_data = 0;
	logic in_valid = 0;
	logic in_stall;
	logic op = OP_LOAD;
	logic [3:0] quad_slot = 0;
	logic [1:0] vertex_index = 0;
	logic signed [15:0] vertex_x = 0;
	logic signed [15:0] vertex_y = 0;
	logic [15:0] rand_quad = 0;
	logic [15:0] rand_triangle = 0;
	logic [15:0] rand_u = 0;
	logic [15:0] rand_v = 0;
	logic out_valid;
	logic out_stall = 0;
	logic [1:0] status;
	logic signed [15:0] point_x;
	logic signed [15:0] point_y;
	logic [3:0] chosen_slot;
	logic second_triangle;

	point_scoreboard sb = new();
	int unsigned cycle = 0;
	int hold_left = 0;
	bit done_hold = 0;

	area_weighted_quad_point_sampler dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_stall(in_stall),
		.op(op), .quad_slot(quad_slot), .vertex_index(vertex_index),
		.vertex_x(vertex_x), .vertex_y(vertex_y),
		.rand_quad(rand_quad), .rand_triangle(rand_triangle),
		.rand_u(rand_u), .rand_v(rand_v),
		.out_valid(out_valid), .out_stall(out_stall),
		.status(status), .point_x(point_x), .point_y(point_y),
		.chosen_slot(chosen_slot), .second_triangle(second_triangle)
	);

	always begin
		#2 clk = 1;
		#2 clk = 0;
	end

	// receiver: own stall pattern plus one long hold-off and rare shorter ones
	always @(posedge clk) begin
		cycle <= cycle + 1;
		if (out_valid && !out_stall)
			sb.check_point('{status, point_x, point_y, chosen_slot, second_triangle});
		if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			out_stall <= 1;
		end else if (!done_hold && cycle > 3000) begin
			done_hold <= 1;
			hold_left <= 400;
			out_stall <= 1;
		end else if ($urandom_range(0, 1999) == 0) begin
			hold_left <= 60;
			out_stall <= 1;
		end else begin
			out_stall <= (cycle[6:5] == 2'b11) ? 1'($urandom_range(0, 1)) : 1'b0;
		end
	end

	task automatic send_word(word_t w);
		int gap;
		op <= w.op;
		quad_slot <= w.slot;
		vertex_index <= w.corner;
		vertex_x <= w.x;
		vertex_y <= w.y;
		rand_quad <= w.rq;
		rand_triangle <= w.rt;
		rand_u <= w.ru;
		rand_v <= w.rv;
		in_valid <= 1;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		sb.note_word(w);
		// bursts with random gaps
		if ($urandom_range(0, 5) == 0) begin
			gap = $urandom_range(1, 12);
			in_valid <= 0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic load_corner(int s, int c, int x, int y);
		word_t w;
		w = '{OP_LOAD, s[3:0], c[1:0], x[15:0], y[15:0],
			16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom)};
		send_word(w);
	endtask

	task automatic draw(logic [15:0] rq, logic [15:0] rt, logic [15:0] ru, logic [15:0] rv);
		word_t w;
		w = '{OP_SAMPLE, 4'($urandom), 2'($urandom), 16'($urandom), 16'($urandom),
			rq, rt, ru, rv};
		send_word(w);
	endtask

	task automatic set_quads(logic [4:0] n);
		in_valid <= 0;
		@(posedge clk);
		while (sb.pending.size() != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);
		cfg_data <= n;
		cfg_valid <= 1;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 0;
		sb.active_quads = n;
	endtask

	function automatic logic [15:0] pick_coord();
		case ($urandom_range(0, 4))
			0: return 16'h8000;
			1: return 16'h7fff;
			2: return 16'($urandom_range(0, 200) - 100);
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic logic [15:0] pick_frac();
		case ($urandom_range(0, 7))
			0: return 16'h0000;
			1: return 16'hffff;
			default: return 16'($urandom);
		endcase
	endfunction

	initial begin
		logic [4:0] counts[8];
		int k;
		counts = '{5'd1, 5'd16, 5'd2, 5'd31, 5'd0, 5'd5, 5'd17, 5'd3};
		repeat (11) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		set_quads(0);
		draw(16'h1234, 16'h5678, 16'h9abc, 16'hdef0);
		// fill every slot: slot 0 spans the full range, slot 1 collapses to a point
		for (int s = 0; s < 16; s++)
			for (int c = 0; c < 4; c++)
				if (s == 0)
					load_corner(s, c, (c == 0 || c == 3) ? -32768 : 32767,
						(c < 2) ? -32768 : 32767);
				else if (s == 1)
					load_corner(s, c, -5, 7);
				else
					load_corner(s, c, pick_coord(), pick_coord());
		set_quads(2);
		draw(16'h0000, 16'h0000, 16'h0000, 16'h0000);
		draw(16'hffff, 16'hffff, 16'hffff, 16'hffff);
		draw(16'h4000, 16'h8000, 16'hc000, 16'hc000);
		draw(16'h0001, 16'hffff, 16'hffff, 16'h0001);
		draw(16'hffff, 16'h0000, 16'h8000, 16'h8000);
		set_quads(1);
		draw(16'h8000, 16'h8000, 16'h8001, 16'h8000);
		draw(16'h8000, 16'h7fff, 16'h0000, 16'hffff);
		set_quads(31);
		draw(16'hffff, 16'h8000, 16'h1111, 16'h2222);
		for (int p = 0; p < 8; p++) begin
			set_quads(p == 7 ? 5'($urandom_range(0, 31)) : counts[p]);
			for (k = 0; k < 110; k++) begin
				if ($urandom_range(0, 3) == 0) begin
					load_corner($urandom_range(0, 15), $urandom_range(0, 3),
						pick_coord(), pick_coord());
				end else begin
					draw(pick_frac(), pick_frac(), pick_frac(), pick_frac());
				end
			end
		end
		in_valid <= 0;
		@(posedge clk);
		while (sb.pending.size() != 0)
			@(posedge clk);
		repeat (50) @(posedge clk);
		if (sb.errors == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

	initial begin
		#20ms;
		$display("CHECK FAILED");
		$finish;
	end

endmodule

FILE: area_weighted_quad_point_sampler.f
hdl/awqps_pkg.sv
hdl/awqps_ram.sv
hdl/area_weighted_quad_point_sampler.sv
tb/area_weighted_quad_point_sampler_test.sv
